// ===== src/elcd_pkg.sv =====
`timescale 1ns / 1ps

package elcd_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam int KEY_W     = 64;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int TTL_W     = 16;

  localparam logic [TTL_W-1:0] TTL_RESET = 16'd120;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

endpackage

// ===== src/expiring_lru_cache_directory_unit.sv =====
`timescale 1ns / 1ps
// Lookup: the item is latched, the entry memory is scanned in S_SCAN, and the result is
// registered in S_WRITE. Update: goes from S_IDLE straight to S_WRITE, where the result is registered.
// One item at a time: no new item is taken until the last one has been written in S_WRITE;
// a lookup scans the entry memory serially, one entry per cycle.
// A waiting result does not block the next item's scan. Synchronous active-low
// reset clears all valid bits and sets the ttl (cfg_ttl_r) to 120; keys and times are not cleared.
module expiring_lru_cache_directory_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [elcd_pkg::KEY_W-1:0]  in_key,
  input  logic [elcd_pkg::TIME_W-1:0] in_now,
  input  logic [elcd_pkg::SLOT_W-1:0] in_slot,
  input  logic                        in_expires_valid,
  input  logic [elcd_pkg::TIME_W-1:0] in_expires_time,
  input  logic                        in_after_miss,
  input  logic                        in_touch,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [elcd_pkg::SLOT_W-1:0] out_slot_out,
  output logic                        out_hit,
  output logic                        out_expired,
  output logic                        out_evicted,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [elcd_pkg::TTL_W-1:0]  cfg_data
);
  import elcd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

  state_t              state_r;
  logic [TTL_W-1:0]    cfg_ttl_r;
  logic [ENTRIES-1:0]  valid_r;

  // latched request
  logic                req_mode_r;
  logic [KEY_W-1:0]    req_key_r;
  logic [TIME_W-1:0]   req_now_r;
  logic [SLOT_W-1:0]   req_slot_r;
  logic                req_exp_valid_r;
  logic [TIME_W-1:0]   req_exp_time_r;
  logic                req_after_miss_r;
  logic                req_touch_r;

  // scan
  logic [CNT_W-1:0]    scan_r;
  logic                scan_lt;
  logic                cmp_vld_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                cmp_entry_vld;
  logic                cmp_key_eq;
  logic                cmp_older;

  logic                match_f_r;
  logic [IDX_W-1:0]    match_idx_r;
  logic [TIME_W-1:0]   match_exp_r;
  logic                free_f_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic                lru_f_r;
  logic [IDX_W-1:0]    lru_idx_r;
  logic [TIME_W-1:0]   lru_time_r;

  // entry memories
  logic [KEY_W-1:0]    key_mem   [ENTRIES];
  logic [TIME_W-1:0]   acc_mem   [ENTRIES];
  logic [TIME_W-1:0]   exp_mem   [ENTRIES];
  logic [KEY_W-1:0]    rd_key_r;
  logic [TIME_W-1:0]   rd_acc_r;
  logic [TIME_W-1:0]   rd_exp_r;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;

  // write controls
  logic                wr_go;
  logic [IDX_W-1:0]    wr_idx;
  logic                wr_key_en;
  logic                wr_acc_en;
  logic                wr_exp_en;
  logic [TIME_W-1:0]   wr_exp_data;
  logic [TIME_W:0]     ttl_sum;
  logic [TIME_W-1:0]   now_plus_ttl;
  logic                upd_in_range;
  logic                hit_fresh;
  logic [IDX_W-1:0]    victim_idx;
  logic [SLOT_W-1:0]   res_slot;

  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_hit_r;
  logic                out_expired_r;
  logic                out_evicted_r;

  assign in_ready     = (state_r == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_slot_out = out_slot_r;
  assign out_hit      = out_hit_r;
  assign out_expired  = out_expired_r;
  assign out_evicted  = out_evicted_r;

  assign scan_lt = (scan_r < CNT_W'(ENTRIES));
  assign rd_en   = (state_r == S_SCAN) && scan_lt;
  assign rd_addr = scan_r[IDX_W-1:0];

  assign cmp_entry_vld = valid_r[cmp_idx_r];
  assign cmp_key_eq    = (rd_key_r == req_key_r);
  assign cmp_older     = (rd_acc_r <= lru_time_r);

  // saturate now + ttl at the top of the time range
  assign ttl_sum      = {1'b0, req_now_r} + {{(TIME_W + 1 - TTL_W){1'b0}}, cfg_ttl_r};
  assign now_plus_ttl = ttl_sum[TIME_W] ? '1 : ttl_sum[TIME_W-1:0];

  assign upd_in_range = (32'(req_slot_r) < ENTRIES);
  assign hit_fresh    = (match_exp_r >= req_now_r);
  assign victim_idx   = free_f_r ? free_idx_r : lru_idx_r;

  always_comb begin
    wr_go       = (state_r == S_WRITE) && (!out_valid_r || out_ready);
    wr_idx      = victim_idx;
    wr_key_en   = 1'b0;
    wr_acc_en   = 1'b0;
    wr_exp_en   = 1'b0;
    wr_exp_data = now_plus_ttl;
    res_slot    = SLOT_W'(victim_idx);
    if (req_mode_r == MODE_UPDATE) begin
      wr_idx    = IDX_W'(req_slot_r);
      res_slot  = req_slot_r;
      wr_exp_en = wr_go && upd_in_range;
      wr_acc_en = wr_go && upd_in_range && req_touch_r;
      if (req_exp_valid_r) begin
        wr_exp_data = req_exp_time_r;
      end else if (!req_after_miss_r) begin
        wr_exp_data = req_now_r;
      end
    end else if (match_f_r) begin
      wr_idx    = match_idx_r;
      res_slot  = SLOT_W'(match_idx_r);
      wr_acc_en = wr_go && hit_fresh;
    end else begin
      wr_key_en = wr_go;
      wr_acc_en = wr_go;
      wr_exp_en = wr_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_acc_r <= acc_mem[rd_addr];
      rd_exp_r <= exp_mem[rd_addr];
    end
    if (wr_key_en) begin
      key_mem[wr_idx] <= req_key_r;
    end
    if (wr_acc_en) begin
      acc_mem[wr_idx] <= req_now_r;
    end
    if (wr_exp_en) begin
      exp_mem[wr_idx] <= wr_exp_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_ttl_r   <= TTL_RESET;
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_ttl_r <= cfg_data;
      end
      if (out_valid_r && out_ready && !wr_go) begin
        out_valid_r <= 1'b0;
      end
      cmp_vld_r <= rd_en;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_mode_r       <= in_mode;
            req_key_r        <= in_key;
            req_now_r        <= in_now;
            req_slot_r       <= in_slot;
            req_exp_valid_r  <= in_expires_valid;
            req_exp_time_r   <= in_expires_time;
            req_after_miss_r <= in_after_miss;
            req_touch_r      <= in_touch;
            scan_r           <= '0;
            match_f_r        <= 1'b0;
            free_f_r         <= 1'b0;
            lru_f_r          <= 1'b0;
            state_r          <= (in_mode == MODE_UPDATE) ? S_WRITE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_lt) begin
            scan_r    <= scan_r + CNT_W'(1);
            cmp_idx_r <= rd_addr;
          end else begin
            state_r <= S_WRITE;
          end
          if (cmp_vld_r) begin
            // lowest matching index wins
            if (cmp_entry_vld && cmp_key_eq && !match_f_r) begin
              match_f_r   <= 1'b1;
              match_idx_r <= cmp_idx_r;
              match_exp_r <= rd_exp_r;
            end
            if (!cmp_entry_vld && !free_f_r) begin
              free_f_r   <= 1'b1;
              free_idx_r <= cmp_idx_r;
            end
            // oldest access among valid entries, ties to the higher index
            if (cmp_entry_vld && !free_f_r && (!lru_f_r || cmp_older)) begin
              lru_f_r    <= 1'b1;
              lru_idx_r  <= cmp_idx_r;
              lru_time_r <= rd_acc_r;
            end
          end
        end
        S_WRITE: begin
          if (wr_go) begin
            out_valid_r   <= 1'b1;
            out_slot_r    <= res_slot;
            out_hit_r     <= (req_mode_r == MODE_LOOKUP) && match_f_r;
            out_expired_r <= (req_mode_r == MODE_LOOKUP) && match_f_r && !hit_fresh;
            out_evicted_r <= (req_mode_r == MODE_LOOKUP) && !match_f_r && !free_f_r;
            if ((req_mode_r == MODE_LOOKUP) && !match_f_r) begin
              valid_r[victim_idx] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/elcd_checker.sv =====
`timescale 1ns / 1ps

module elcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [elcd_pkg::SLOT_W-1:0] out_slot_out,
  input logic                        out_hit,
  input logic                        out_expired,
  input logic                        out_evicted
);
  import elcd_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_out) && $stable(out_hit)
      && $stable(out_expired) && $stable(out_evicted))
    else $error("stalled result changed");

  // busy after taking an item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired |-> out_hit)
    else $error("expired without hit");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit)
    else $error("eviction on a hit");

endmodule

bind expiring_lru_cache_directory_unit elcd_checker u_elcd_checker (.*);

// ===== verif/expiring_lru_cache_directory_unit_tb.sv =====
`timescale 1ns / 1ps

module expiring_lru_cache_directory_unit_tb;
  import elcd_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int POOL_KEYS   = 24;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 210;
  localparam int SETTLE      = 24;

  typedef struct {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [SLOT_W-1:0] slot;
    logic              exp_ok;
    logic [TIME_W-1:0] exp_t;
    logic              after_miss;
    logic              touch;
  } req_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              expired;
    logic              evicted;
  } outcome_t;

  typedef struct {
    req_t     req;
    bit       typed;
    outcome_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [KEY_W-1:0] in_key = '0;
  logic [TIME_W-1:0] in_now = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic in_expires_valid = 1'b0;
  logic [TIME_W-1:0] in_expires_time = '0;
  logic in_after_miss = 1'b0;
  logic in_touch = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SLOT_W-1:0] out_slot_out;
  logic out_hit;
  logic out_expired;
  logic out_evicted;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TTL_W-1:0] cfg_data = '0;

  // shadow copy of the directory
  logic              vld_tab [ENTRIES];
  logic [KEY_W-1:0]  key_tab [ENTRIES];
  logic [TIME_W-1:0] acc_tab [ENTRIES];
  logic [TIME_W-1:0] exp_tab [ENTRIES];
  logic [TTL_W-1:0]  ttl_q = TTL_RESET;

  outcome_t pending_results[$];
  row_t plan[$];
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;

  expiring_lru_cache_directory_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_now          (in_now),
    .in_slot         (in_slot),
    .in_expires_valid(in_expires_valid),
    .in_expires_time (in_expires_time),
    .in_after_miss   (in_after_miss),
    .in_touch        (in_touch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_out    (out_slot_out),
    .out_hit         (out_hit),
    .out_expired     (out_expired),
    .out_evicted     (out_evicted),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a,
                                                input logic [TTL_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + b;
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic outcome_t resolve_request(input req_t q);
    outcome_t o;
    int i;
    int victim;
    bit found_free;
    o = '{slot: q.slot, hit: 1'b0, expired: 1'b0, evicted: 1'b0};
    if (q.mode == MODE_UPDATE) begin
      if (int'(q.slot) < ENTRIES) begin
        if (q.exp_ok) exp_tab[q.slot] = q.exp_t;
        else if (q.after_miss) exp_tab[q.slot] = sat_sum(q.now, ttl_q);
        else exp_tab[q.slot] = q.now;
        if (q.touch) acc_tab[q.slot] = q.now;
      end
      return o;
    end
    // lowest matching index wins
    for (i = 0; i < ENTRIES; i++) begin
      if (vld_tab[i] && key_tab[i] == q.key) begin
        o.slot = SLOT_W'(i);
        o.hit = 1'b1;
        if (exp_tab[i] >= q.now) acc_tab[i] = q.now;
        else o.expired = 1'b1;
        return o;
      end
    end
    // first free entry, else oldest access with ties to the higher index
    victim = 0;
    found_free = 1'b0;
    for (i = 0; i < ENTRIES; i++) begin
      if (!vld_tab[i]) begin
        victim = i;
        found_free = 1'b1;
        break;
      end
      if (acc_tab[i] <= acc_tab[victim]) victim = i;
    end
    vld_tab[victim] = 1'b1;
    key_tab[victim] = q.key;
    acc_tab[victim] = q.now;
    exp_tab[victim] = sat_sum(q.now, ttl_q);
    o.slot = SLOT_W'(victim);
    o.evicted = !found_free;
    return o;
  endfunction

  function automatic req_t lk(input logic [KEY_W-1:0] k, input logic [TIME_W-1:0] t);
    req_t q;
    q = '{default: '0};
    q.mode = MODE_LOOKUP;
    q.key = k;
    q.now = t;
    return q;
  endfunction

  function automatic req_t up(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] t,
                              input logic eok, input logic [TIME_W-1:0] et,
                              input logic am, input logic tch);
    req_t q;
    q = '{default: '0};
    q.mode = MODE_UPDATE;
    q.slot = s;
    q.now = t;
    q.exp_ok = eok;
    q.exp_t = et;
    q.after_miss = am;
    q.touch = tch;
    return q;
  endfunction

  function automatic outcome_t res(input logic [SLOT_W-1:0] s, input logic h,
                                   input logic e, input logic v);
    return '{slot: s, hit: h, expired: e, evicted: v};
  endfunction

  function automatic void add_row(input req_t q, input bit typed, input outcome_t w);
    row_t r;
    r.req = q;
    r.typed = typed;
    r.want = w;
    plan.push_back(r);
  endfunction

  // starts and ends at a falling edge
  task automatic send_item(input req_t q, input bit typed, input outcome_t want);
    outcome_t got;
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    in_mode = q.mode;
    in_key = q.key;
    in_now = q.now;
    in_slot = q.slot;
    in_expires_valid = q.exp_ok;
    in_expires_time = q.exp_t;
    in_after_miss = q.after_miss;
    in_touch = q.touch;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    got = resolve_request(q);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic drain(input int settle);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_ttl(input logic [TTL_W-1:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    ttl_q = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready = calm || ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk) begin : watch
    outcome_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result for slot %0d with nothing pending", out_slot_out);
        mismatches++;
      end else begin
        w = pending_results.pop_front();
        if (out_slot_out !== w.slot) begin
          $error("slot_out: expected %0d, got %0d", w.slot, out_slot_out);
          mismatches++;
        end
        if (out_hit !== w.hit) begin
          $error("hit: expected %0d, got %0d", w.hit, out_hit);
          mismatches++;
        end
        if (out_expired !== w.expired) begin
          $error("expired: expected %0d, got %0d", w.expired, out_expired);
          mismatches++;
        end
        if (out_evicted !== w.evicted) begin
          $error("evicted: expected %0d, got %0d", w.evicted, out_evicted);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0]  key_pool [POOL_KEYS];
    logic [TTL_W-1:0]  ttls [PHASES];
    logic [TIME_W-1:0] cur_time;
    req_t q;
    int p;
    int n;
    int r;

    foreach (vld_tab[i]) begin
      vld_tab[i] = 1'b0;
      key_tab[i] = '0;
      acc_tab[i] = '0;
      exp_tab[i] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    ttls = '{16'd0, 16'hFFFF, 16'd1, 16'd600, 16'($urandom)};

    // reset value of the ttl (120) holds for the directed rows
    add_row(lk(64'd0, 32'd0), 1'b1, res(4'd0, 1'b0, 1'b0, 1'b0));
    add_row(lk(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF), 1'b1, res(4'd1, 1'b0, 1'b0, 1'b0));
    // expiry equal to now is still fresh, one time unit later it is not
    add_row(lk(64'd0, 32'd120), 1'b1, res(4'd0, 1'b1, 1'b0, 1'b0));
    add_row(lk(64'd0, 32'd121), 1'b1, res(4'd0, 1'b1, 1'b1, 1'b0));
    add_row(up(4'd0, 32'd200, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1), 1'b1,
            res(4'd0, 1'b0, 1'b0, 1'b0));
    add_row(lk(64'd0, 32'hFFFF_FFFF), 1'b1, res(4'd0, 1'b1, 1'b0, 1'b0));
    // updates of entries not yet valid
    add_row(up(4'd5, 32'hFFFF_FFF0, 1'b0, 32'd0, 1'b1, 1'b0), 1'b1,
            res(4'd5, 1'b0, 1'b0, 1'b0));
    add_row(up(4'd15, 32'd5, 1'b0, 32'd0, 1'b0, 1'b1), 1'b1,
            res(4'd15, 1'b0, 1'b0, 1'b0));
    // now + ttl saturates, so the entry stays fresh at the top of time
    add_row(up(4'd1, 32'hFFFF_FFC0, 1'b0, 32'd0, 1'b1, 1'b0), 1'b1,
            res(4'd1, 1'b0, 1'b0, 1'b0));
    add_row(lk(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF), 1'b1, res(4'd1, 1'b1, 1'b0, 1'b0));
    // fill the rest with one access time, then evict on a tie
    for (n = 2; n < ENTRIES; n++) add_row(lk(64'(n), 32'd300), 1'b0, res(4'd0, 1'b0, 1'b0, 1'b0));
    add_row(lk(64'h100, 32'd301), 1'b0, res(4'd0, 1'b0, 1'b0, 1'b0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_item(plan[i].req, plan[i].typed, plan[i].want);

    for (p = 0; p < PHASES; p++) begin
      in_valid = 1'b0;
      drain(SETTLE);
      write_ttl(ttls[p]);
      cur_time = (p % 2) ? 32'hFFFF_0000 + $urandom_range(0, 60000) : $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        calm = (p == 2) && (n >= 20) && (n < 200);
        r = $urandom_range(0, 99);
        if (r < 30) cur_time = cur_time;
        else if (r < 80) cur_time = cur_time + $urandom_range(1, 4);
        else if (r < 95) cur_time = cur_time + $urandom_range(1, 300);
        else cur_time = $urandom;
        q.mode = ($urandom_range(0, 99) < 25) ? MODE_UPDATE : MODE_LOOKUP;
        q.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                             : {$urandom, $urandom};
        q.now = cur_time;
        q.slot = SLOT_W'($urandom_range(0, 15));
        q.exp_ok = 1'($urandom_range(0, 1));
        q.exp_t = $urandom_range(0, 1) ? cur_time + $urandom_range(0, 400) - 200 : $urandom;
        q.after_miss = 1'($urandom_range(0, 1));
        q.touch = 1'($urandom_range(0, 1));
        send_item(q, 1'b0, res(4'd0, 1'b0, 1'b0, 1'b0));
      end
    end
    calm = 1'b0;
    in_valid = 1'b0;

    drain(30);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/elcd_pkg.sv
src/expiring_lru_cache_directory_unit.sv
src/elcd_checker.sv
verif/expiring_lru_cache_directory_unit_tb.sv
